### rtl/core/assert_macros.svh
// Assertion macros shared by the facet normal RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is high.
`define QFN_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define QFN_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/core/qfn_pkg.sv
// Package with widths, types and helpers of the quad facet normal unit.
package qfn_pkg;

   localparam int COORD_BITS = 24;
   localparam int NORMAL_FRAC_BITS = 14;
   localparam int NUM_CORNERS = 4;
   localparam int NUM_AXES = 3;
   localparam int REQ_DATA_W = NUM_CORNERS * NUM_AXES * COORD_BITS;
   localparam int EDGE_W = COORD_BITS + 1;
   localparam int PROD_W = 2 * EDGE_W;
   localparam int CROSS_W = PROD_W + 1;
   localparam int MAG_W = PROD_W;
   localparam int HALF_W = (MAG_W + 1) / 2;
   localparam int LOW_W = MAG_W - HALF_W;
   localparam int PP_W = 2 * HALF_W;
   localparam int SQ_W = 2 * MAG_W;
   localparam int SUM_W = SQ_W + 2;
   localparam int A_W = SQ_W + 2 * NORMAL_FRAC_BITS + 2;
   localparam int Q_W = NORMAL_FRAC_BITS + 1;
   localparam int PW = SUM_W + Q_W + 3;
   localparam int RES_W = A_W + 10;
   localparam int OUT_W = 16;
   localparam int LANE_LAT = Q_W + 1;
   localparam int RSP_DATA_W = ((3 * OUT_W + 1 + 7) / 8) * 8;

   // Control flags that travel with one triangle through the pipeline.
   typedef struct packed {
      logic valid;
      logic second;
      logic degen;
   } tag_type;

   // Extracts one signed coordinate from the packed request word.
   function automatic logic signed [COORD_BITS-1:0] coord_of(
      input logic [REQ_DATA_W-1:0] data, input int corner, input int axis);
      coord_of = data[(corner * NUM_AXES + axis) * COORD_BITS +: COORD_BITS];
   endfunction

endpackage

### rtl/core/qfn_unit_lane.sv
// Digit recurrence that rounds one normal component to Q2.14, one bit a stage.
module qfn_unit_lane (
   input  logic                        clock,
   input  logic                        enable,
   input  logic [qfn_pkg::SUM_W-1:0]   sum_in,
   input  logic [qfn_pkg::A_W-1:0]     lhs_in,
   input  logic                        neg_in,
   output logic [qfn_pkg::Q_W-1:0]     q_out,
   output logic                        neg_out
);
   import qfn_pkg::*;

   logic signed [RES_W-1:0] r_ff   [Q_W+1];
   logic signed [PW-1:0]    p_ff   [Q_W+1];
   logic [Q_W-1:0]          q_ff   [Q_W+1];
   logic [SUM_W-1:0]        s_ff   [Q_W+1];
   logic                    neg_ff [Q_W+1];

   // Initial residue holds 4*n^2*2^(2F) minus S for the candidate q = 0.
   always_ff @(posedge clock) begin
      if (enable) begin
         r_ff[0]   <= RES_W'(lhs_in) - RES_W'(sum_in);
         p_ff[0]   <= -PW'(sum_in);
         q_ff[0]   <= '0;
         s_ff[0]   <= sum_in;
         neg_ff[0] <= neg_in;
      end
   end

   // Each stage tries one bit of q, highest first, by shifts and adds only.
   for (genvar i = 0; i < Q_W; i++) begin : g_step
      localparam int B = Q_W - 1 - i;
      logic signed [RES_W-1:0] p_ext;
      logic signed [RES_W-1:0] trial;
      logic                    take;

      always_comb begin
         p_ext = {{(RES_W-PW){p_ff[i][PW-1]}}, p_ff[i]};
         trial = r_ff[i] - (p_ext <<< (B + 2)) - (RES_W'(s_ff[i]) << (2 * B + 2));
         take  = !trial[RES_W-1] && !q_ff[i][Q_W-1];
      end

      always_ff @(posedge clock) begin
         if (enable) begin
            s_ff[i+1]   <= s_ff[i];
            neg_ff[i+1] <= neg_ff[i];
            if (take) begin
               r_ff[i+1] <= trial;
               p_ff[i+1] <= p_ff[i] + (PW'(s_ff[i]) << (B + 1));
               q_ff[i+1] <= q_ff[i] | (Q_W'(1) << B);
            end else begin
               r_ff[i+1] <= r_ff[i];
               p_ff[i+1] <= p_ff[i];
               q_ff[i+1] <= q_ff[i];
            end
         end
      end
   end

   assign q_out   = q_ff[Q_W];
   assign neg_out = neg_ff[Q_W];

endmodule

### rtl/core/quad_facet_normal_unit.sv
// Top level of the quad facet normal unit: two triangle unit normals per quad.
// Each accepted quad yields two result transactions, triangle (c0,c1,c2) then
// (c0,c2,c3), both through one shared pipeline, so the next quad is accepted
// as the second triangle of the held one issues. From the hold register to
// the result there are seven arithmetic stages (edges, products, cross
// product, magnitude, partial squares, squares, norm sum), sixteen stages of
// the per-component rounding recurrence, and the output register. The whole
// pipeline stalls together while a result waits. Normals are Q2.14, rounded
// to nearest; a zero cross product gives a zero normal with degenerate set.
module quad_facet_normal_unit (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // c0_x, c0_y, c0_z, c1_x, ... c3_z, 24 bits each, from bit 0 up.
   input  logic [qfn_pkg::REQ_DATA_W-1:0]   req_tdata,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // normal_x [15:0], normal_y [31:16], normal_z [47:32], degenerate [48], zero pad.
   output logic [qfn_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // second_triangle.
   output logic                             rsp_tuser,
   output logic                             rsp_tlast
);
   import qfn_pkg::*;
   `include "assert_macros.svh"

   logic                  adv;
   logic                  issue;
   logic                  done_quad;
   logic                  accept;
   logic [REQ_DATA_W-1:0] hold_ff;
   logic                  hold_valid_ff, hold_valid_in;
   logic                  tri_sel_ff, tri_sel_in;

   tag_type               tag_ff [1:7];
   tag_type               dly_ff [LANE_LAT];

   logic signed [EDGE_W-1:0]  eu_ff [NUM_AXES];
   logic signed [EDGE_W-1:0]  ev_ff [NUM_AXES];
   logic signed [PROD_W-1:0]  pr_ff [6];
   logic signed [CROSS_W-1:0] n_ff  [NUM_AXES];
   logic [MAG_W-1:0]          mag_ff [NUM_AXES];
   logic [PP_W-1:0]           hh_ff [NUM_AXES];
   logic [PP_W-1:0]           hl_ff [NUM_AXES];
   logic [PP_W-1:0]           ll_ff [NUM_AXES];
   logic [SQ_W-1:0]           sq6_ff [NUM_AXES];
   logic [SQ_W-1:0]           sq7_ff [NUM_AXES];
   logic [SUM_W-1:0]          sum_ff;
   logic                      neg4_ff [NUM_AXES];
   logic                      neg5_ff [NUM_AXES];
   logic                      neg6_ff [NUM_AXES];
   logic                      neg7_ff [NUM_AXES];
   logic [Q_W-1:0]            lane_q   [NUM_AXES];
   logic                      lane_neg [NUM_AXES];

   logic                      rsp_valid_ff;
   logic signed [OUT_W-1:0]   rsp_norm_ff [NUM_AXES];
   logic                      rsp_degen_ff, rsp_second_ff;

   // The whole pipeline moves when the output register is free or drained.
   assign adv        = !rsp_valid_ff || rsp_tready;
   assign issue      = adv && hold_valid_ff;
   assign done_quad  = issue && tri_sel_ff;
   assign req_tready = !hold_valid_ff || done_quad;
   assign accept     = req_tvalid && req_tready;

   // Quad hold register and triangle sequencer.
   always_comb begin
      hold_valid_in = hold_valid_ff;
      tri_sel_in    = tri_sel_ff;
      if (accept) begin
         hold_valid_in = 1'b1;
      end else if (done_quad) begin
         hold_valid_in = 1'b0;
      end
      if (done_quad) begin
         tri_sel_in = 1'b0;
      end else if (issue) begin
         tri_sel_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
         tri_sel_ff    <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
         tri_sel_ff    <= tri_sel_in;
      end
      if (accept) begin
         hold_ff <= req_tdata;
      end
   end

   // Valid bits and flags of the arithmetic stages.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 1; s <= 7; s++) begin
            tag_ff[s] <= '0;
         end
         for (int d = 0; d < LANE_LAT; d++) begin
            dly_ff[d] <= '0;
         end
      end else if (adv) begin
         tag_ff[1] <= '{valid: hold_valid_ff, second: tri_sel_ff, degen: 1'b0};
         tag_ff[2] <= tag_ff[1];
         tag_ff[3] <= tag_ff[2];
         tag_ff[4] <= '{valid: tag_ff[3].valid, second: tag_ff[3].second,
                        degen: (n_ff[0] == '0) && (n_ff[1] == '0) && (n_ff[2] == '0)};
         tag_ff[5] <= tag_ff[4];
         tag_ff[6] <= tag_ff[5];
         tag_ff[7] <= tag_ff[6];
         dly_ff[0] <= tag_ff[7];
         for (int d = 1; d < LANE_LAT; d++) begin
            dly_ff[d] <= dly_ff[d-1];
         end
      end
   end

   // Edge vectors, products, cross product, magnitudes and squares.
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < NUM_AXES; k++) begin
            eu_ff[k] <= EDGE_W'(coord_of(hold_ff, tri_sel_ff ? 2 : 1, k))
                      - EDGE_W'(coord_of(hold_ff, 0, k));
            ev_ff[k] <= EDGE_W'(coord_of(hold_ff, tri_sel_ff ? 3 : 2, k))
                      - EDGE_W'(coord_of(hold_ff, 0, k));
         end
         pr_ff[0] <= eu_ff[1] * ev_ff[2];
         pr_ff[1] <= eu_ff[2] * ev_ff[1];
         pr_ff[2] <= eu_ff[2] * ev_ff[0];
         pr_ff[3] <= eu_ff[0] * ev_ff[2];
         pr_ff[4] <= eu_ff[0] * ev_ff[1];
         pr_ff[5] <= eu_ff[1] * ev_ff[0];
         for (int k = 0; k < NUM_AXES; k++) begin
            n_ff[k] <= CROSS_W'(pr_ff[2*k]) - CROSS_W'(pr_ff[2*k+1]);
            mag_ff[k]  <= n_ff[k][CROSS_W-1] ? MAG_W'(-n_ff[k]) : MAG_W'(n_ff[k]);
            neg4_ff[k] <= n_ff[k][CROSS_W-1];
            hh_ff[k]   <= PP_W'(mag_ff[k][MAG_W-1:LOW_W]) * PP_W'(mag_ff[k][MAG_W-1:LOW_W]);
            hl_ff[k]   <= PP_W'(mag_ff[k][MAG_W-1:LOW_W]) * PP_W'(mag_ff[k][LOW_W-1:0]);
            ll_ff[k]   <= PP_W'(mag_ff[k][LOW_W-1:0]) * PP_W'(mag_ff[k][LOW_W-1:0]);
            neg5_ff[k] <= neg4_ff[k];
            sq6_ff[k]  <= (SQ_W'(hh_ff[k]) << (2 * LOW_W)) + (SQ_W'(hl_ff[k]) << (LOW_W + 1))
                        + SQ_W'(ll_ff[k]);
            neg6_ff[k] <= neg5_ff[k];
            sq7_ff[k]  <= sq6_ff[k];
            neg7_ff[k] <= neg6_ff[k];
         end
         sum_ff <= SUM_W'(sq6_ff[0]) + SUM_W'(sq6_ff[1]) + SUM_W'(sq6_ff[2]);
      end
   end

   // One rounding recurrence per normal component.
   for (genvar k = 0; k < NUM_AXES; k++) begin : g_lane
      qfn_unit_lane u_lane (
         .clock   (clock),
         .enable  (adv),
         .sum_in  (sum_ff),
         .lhs_in  ({sq7_ff[k], (2 * NORMAL_FRAC_BITS + 2)'(0)}),
         .neg_in  (neg7_ff[k]),
         .q_out   (lane_q[k]),
         .neg_out (lane_neg[k])
      );
   end

   // Output register: sign applied, degenerate triangles forced to zero.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= dly_ff[LANE_LAT-1].valid;
      end
      if (adv) begin
         rsp_degen_ff  <= dly_ff[LANE_LAT-1].degen;
         rsp_second_ff <= dly_ff[LANE_LAT-1].second;
         for (int k = 0; k < NUM_AXES; k++) begin
            if (dly_ff[LANE_LAT-1].degen) begin
               rsp_norm_ff[k] <= '0;
            end else if (lane_neg[k]) begin
               rsp_norm_ff[k] <= -OUT_W'(lane_q[k]);
            end else begin
               rsp_norm_ff[k] <= OUT_W'(lane_q[k]);
            end
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'({rsp_degen_ff, rsp_norm_ff[2], rsp_norm_ff[1],
                                    rsp_norm_ff[0]});
   assign rsp_tuser  = rsp_second_ff;
   assign rsp_tlast  = rsp_second_ff;

   `QFN_ASSERT(a_second_follows_first, clock, reset, issue && !tri_sel_ff |=> hold_valid_ff && tri_sel_ff, "second triangle not pending after the first issued")
   `QFN_ASSERT(a_degen_zero, clock, reset, rsp_valid_ff && rsp_degen_ff |-> rsp_norm_ff[0] == '0 && rsp_norm_ff[1] == '0 && rsp_norm_ff[2] == '0, "degenerate result with nonzero normal")
   `QFN_ASSERT(a_norm_range, clock, reset, rsp_valid_ff |-> $signed(rsp_norm_ff[0]) <= 16384 && $signed(rsp_norm_ff[0]) >= -16384, "normal x component out of range")
   `QFN_ASSERT(a_no_accept_midquad, clock, reset, hold_valid_ff && !tri_sel_ff |-> !req_tready, "request accepted before the held quad finished")

endmodule

### tb/quad_facet_normal_unit_tb.sv
// Self-checking testbench of the quad facet normal unit with its own normal predictor.
module quad_facet_normal_unit_tb;
   import qfn_pkg::*;

   typedef struct packed {
      logic signed [15:0] nx;
      logic signed [15:0] ny;
      logic signed [15:0] nz;
      logic               degen;
      logic               second;
      logic               last;
   } facet_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tuser;
   logic                  rsp_tlast;

   logic [REQ_DATA_W-1:0] quad_queue[$];
   facet_type             facet_queue[$];
   int                    send_idle_pct = 34;
   int                    recv_idle_pct = 71;
   bit                    send_hold = 1'b0;
   int                    mismatches = 0;
   int                    quads_sent = 0;
   int                    facets_seen = 0;
   int                    degen_seen = 0;

   quad_facet_normal_unit i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always #1 clock = ~clock;

   // Rounded unit normal of triangle (p0, pa, pb), exact to the last bit.
   function automatic facet_type facet_normal(input longint p0[3], input longint pa[3],
                                              input longint pb[3], input bit second);
      logic signed [127:0] u[3];
      logic signed [127:0] v[3];
      logic signed [127:0] n[3];
      logic [255:0]        mag[3];
      logic [255:0]        norm_sq;
      logic [255:0]        lhs;
      logic [255:0]        rhs;
      logic signed [15:0]  comp[3];
      longint              t;
      int                  lo;
      int                  hi;
      int                  mid;
      facet_type           f;
      for (int i = 0; i < 3; i++) begin
         u[i] = pa[i] - p0[i];
         v[i] = pb[i] - p0[i];
      end
      norm_sq = '0;
      for (int i = 0; i < 3; i++) begin
         n[i] = u[(i + 1) % 3] * v[(i + 2) % 3] - u[(i + 2) % 3] * v[(i + 1) % 3];
         mag[i] = 256'(n[i] < 0 ? -n[i] : n[i]);
         norm_sq = norm_sq + mag[i] * mag[i];
      end
      f.second = second;
      f.last = second;
      if (norm_sq == '0) begin
         f.nx = '0;
         f.ny = '0;
         f.nz = '0;
         f.degen = 1'b1;
         return f;
      end
      // Largest q with 4 n^2 2^(2F) >= (2q-1)^2 |n|^2, found by bisection.
      for (int i = 0; i < 3; i++) begin
         lhs = (mag[i] * mag[i]) << (2 * NORMAL_FRAC_BITS + 2);
         lo = 0;
         hi = 1 << NORMAL_FRAC_BITS;
         while (lo < hi) begin
            mid = lo + (hi - lo + 1) / 2;
            t = 2 * mid - 1;
            rhs = 256'(t * t) * norm_sq;
            if (lhs >= rhs) lo = mid;
            else hi = mid - 1;
         end
         comp[i] = (n[i] < 0) ? 16'(-lo) : 16'(lo);
      end
      f.nx = comp[0];
      f.ny = comp[1];
      f.nz = comp[2];
      f.degen = 1'b0;
      return f;
   endfunction

   // Both expected facets of one accepted quad, in output order.
   task automatic predict_quad(input logic [REQ_DATA_W-1:0] d);
      longint c[4][3];
      for (int k = 0; k < 4; k++)
         for (int a = 0; a < 3; a++)
            c[k][a] = longint'($signed(d[(k * 3 + a) * COORD_BITS +: COORD_BITS]));
      facet_queue.push_back(facet_normal(c[0], c[1], c[2], 1'b0));
      facet_queue.push_back(facet_normal(c[0], c[2], c[3], 1'b1));
   endtask

   function automatic logic [REQ_DATA_W-1:0] pack_quad(input int v[12]);
      logic [REQ_DATA_W-1:0] d;
      d = '0;
      for (int k = 0; k < 12; k++)
         d[k * COORD_BITS +: COORD_BITS] = v[k][COORD_BITS-1:0];
      return d;
   endfunction

   // Random quad: mostly full range, some small, some with collinear or repeated corners.
   function automatic logic [REQ_DATA_W-1:0] random_quad();
      int v[12];
      int kind;
      int s;
      kind = $urandom_range(99);
      s = (kind < 55) ? (1 << 23) : (1 << $urandom_range(12, 2));
      for (int k = 0; k < 12; k++)
         v[k] = int'($urandom_range(2 * s - 1)) - s;
      if (kind >= 80 && kind < 90) begin
         // Collinear corners, every triangle degenerate.
         for (int a = 0; a < 3; a++) begin
            v[3 + a] = v[a] + v[6 + a] / 4;
            v[6 + a] = v[a] + 2 * (v[6 + a] / 4);
            v[9 + a] = 2 * v[a] - v[3 + a];
         end
      end else if (kind >= 90) begin
         // One coincident corner pair makes one triangle degenerate.
         for (int a = 0; a < 3; a++) begin
            if (kind & 1) v[9 + a] = v[6 + a];
            else v[3 + a] = v[a];
         end
      end
      return pack_quad(v);
   endfunction

   // Driver: presents quads from the pending queue with random gaps.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            predict_quad(req_tdata);
            quads_sent++;
         end
         if (!req_tvalid || req_tready) begin
            if (quad_queue.size() > 0 && !send_hold &&
                $urandom_range(99) >= send_idle_pct) begin
               req_tvalid <= 1'b1;
               req_tdata <= quad_queue.pop_front();
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Monitor: checks each result transaction against the oldest expected facet.
   always @(posedge clock) begin
      facet_type got;
      facet_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
         if (rsp_tvalid && rsp_tready) begin
            got.nx = rsp_tdata[15:0];
            got.ny = rsp_tdata[31:16];
            got.nz = rsp_tdata[47:32];
            got.degen = rsp_tdata[48];
            got.second = rsp_tuser;
            got.last = rsp_tlast;
            facets_seen++;
            if (got.degen) degen_seen++;
            if (facet_queue.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("ERROR: unexpected result nx=%0d ny=%0d nz=%0d",
                           got.nx, got.ny, got.nz);
            end else begin
               want = facet_queue.pop_front();
               if (got !== want) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display({"ERROR: facet %0d expected n=(%0d,%0d,%0d) dg=%0b sec=%0b ",
                               "last=%0b, got n=(%0d,%0d,%0d) dg=%0b sec=%0b last=%0b"},
                              facets_seen, want.nx, want.ny, want.nz, want.degen,
                              want.second, want.last, got.nx, got.ny, got.nz,
                              got.degen, got.second, got.last);
               end
            end
         end
      end
   end

   // Stimulus and end of test.
   initial begin
      int dir[$][12];
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed quads: zeros, extremes, axis planes, both windings, degenerate cases.
      dir.push_back('{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0});
      dir.push_back('{8388607, 8388607, 8388607, 8388607, 8388607, 8388607,
                      8388607, 8388607, 8388607, 8388607, 8388607, 8388607});
      dir.push_back('{-8388608, -8388608, -8388608, -8388608, -8388608, -8388608,
                      -8388608, -8388608, -8388608, -8388608, -8388608, -8388608});
      dir.push_back('{0, 0, 0, 4096, 0, 0, 4096, 4096, 0, 0, 4096, 0});
      dir.push_back('{0, 0, 0, 0, 4096, 0, 4096, 4096, 0, 4096, 0, 0});
      dir.push_back('{0, 0, 0, 0, 4096, 0, 0, 4096, 4096, 0, 0, 4096});
      dir.push_back('{0, 0, 0, 0, 0, 4096, 4096, 0, 4096, 4096, 0, 0});
      dir.push_back('{-8388608, -8388608, -8388608, 8388607, -8388608, -8388608,
                      -8388608, 8388607, -8388608, -8388608, -8388608, 8388607});
      dir.push_back('{8388607, 8388607, 8388607, -8388608, 8388607, 8388607,
                      8388607, -8388608, 8388607, 8388607, 8388607, -8388608});
      dir.push_back('{8388607, -8388608, 8388607, -8388608, 8388607, -8388608,
                      8388607, 8388607, -8388608, -8388608, -8388608, 8388607});
      dir.push_back('{0, 0, 0, 3, 4, 0, 0, 0, 5, -4, 3, 0});
      dir.push_back('{0, 0, 0, 1, 1, 0, 0, 1, 1, 1, 0, 1});
      dir.push_back('{1, 2, 3, 2, 4, 6, 3, 6, 9, -1, -2, -3});
      dir.push_back('{5, 5, 5, 5, 5, 5, 9, 1, 7, 2, 8, 3});
      dir.push_back('{5, 5, 5, 9, 1, 7, 2, 8, 3, 2, 8, 3});
      dir.push_back('{0, 0, 0, 1, 0, 0, 0, 1, 0, 1, 1, 0});
      dir.push_back('{-1, -1, -1, 1, 1, 1, 1, -1, 1, -1, 1, -1});
      dir.push_back('{0, 0, 0, 8388607, 0, 0, 0, 1, 0, 1, 8388607, 1});
      foreach (dir[i]) quad_queue.push_back(pack_quad(dir[i]));
      for (int i = 0; i < 230; i++) quad_queue.push_back(random_quad());

      // Phases of idling; between them the sender holds until every result is back.
      for (int phase = 0; phase < 3; phase++) begin
         wait (quad_queue.size() == 0 && !req_tvalid);
         send_hold = 1'b1;
         wait (facet_queue.size() == 0);
         @(posedge clock);
         if (phase == 0) begin
            send_idle_pct = 71;
            recv_idle_pct = 34;
         end else if (phase == 1) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         if (phase < 2)
            for (int i = 0; i < 240; i++) quad_queue.push_back(random_quad());
         send_hold = 1'b0;
      end

      repeat (40) @(posedge clock);
      $display("Covered %0d quads (%0d facets, %0d degenerate) under three idle patterns.",
               quads_sent, facets_seen, degen_seen);
      if (mismatches == 0 && facet_queue.size() == 0) begin
         $display("PASS quad_facet_normal_unit");
      end else begin
         $display("%0d mismatches, %0d facets missing", mismatches, facet_queue.size());
         $display("FAIL quad_facet_normal_unit");
      end
      $finish;
   end

   // Watchdog for a hung handshake.
   initial begin
      #400000;
      $display("Timeout with %0d facets outstanding", facet_queue.size());
      $display("FAIL quad_facet_normal_unit");
      $finish;
   end

endmodule
